// ----- rtl/b64d_pkg.sv -----
// Package for the base64url stream decoder: shared constants, the decoded
// group record passed from the front end to the output serializer.
// No dependencies.
`default_nettype none

package b64d_pkg;

  localparam logic [7:0] PAD_CHAR    = 8'h3D;  // '='
  localparam logic [7:0] PLUS_CHAR   = 8'h2B;  // '+'
  localparam logic [7:0] MINUS_CHAR  = 8'h2D;  // '-'
  localparam logic [7:0] SLASH_CHAR  = 8'h2F;  // '/'
  localparam logic [7:0] UNDER_CHAR  = 8'h5F;  // '_'
  localparam logic [7:0] UPPER_A     = 8'h41;
  localparam logic [7:0] UPPER_Z     = 8'h5A;
  localparam logic [7:0] LOWER_A     = 8'h61;
  localparam logic [7:0] LOWER_Z     = 8'h7A;
  localparam logic [7:0] DIGIT_0     = 8'h30;
  localparam logic [7:0] DIGIT_9     = 8'h39;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One decoded group: up to three bytes, how many of them are valid,
  // and whether the group ends the text.
  typedef struct packed {
    logic [23:0] triple;
    logic [1:0]  count;
    logic        fin;
  } group_entry_t;

endpackage

`default_nettype wire

// ----- rtl/b64d_front.sv -----
// Front end of the base64url stream decoder: maps characters to sextets
// and gathers them into groups. Depends on b64d_pkg.
`default_nettype none

module b64d_front
  import b64d_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         char_valid,
  input  wire logic [7:0]   char_code,
  input  wire logic         char_fin,
  output group_entry_t      grp_entry,
  output logic              grp_push
);

  logic [17:0] acc_r, acc_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic        twp_r, twp_nxt;

  logic [5:0]  sextet;
  logic        is_pad;
  logic [17:0] acc_new;
  logic        emit;

  // Both alphabets map onto the same sextet values; anything else is zero.
  always_comb begin
    sextet = 6'd0;
    if (char_code >= UPPER_A && char_code <= UPPER_Z) begin
      sextet = 6'(char_code - UPPER_A);
    end else if (char_code >= LOWER_A && char_code <= LOWER_Z) begin
      sextet = 6'(char_code - LOWER_A + 8'd26);
    end else if (char_code >= DIGIT_0 && char_code <= DIGIT_9) begin
      sextet = 6'(char_code - DIGIT_0 + 8'd52);
    end else if (char_code == PLUS_CHAR || char_code == MINUS_CHAR) begin
      sextet = 6'd62;
    end else if (char_code == SLASH_CHAR || char_code == UNDER_CHAR) begin
      sextet = 6'd63;
    end
  end

  assign is_pad  = (char_code == PAD_CHAR);
  assign acc_new = {acc_r[11:0], sextet};

  always_comb begin
    emit            = 1'b0;
    grp_entry.fin   = char_fin;
    grp_entry.triple = {acc_r, sextet};
    grp_entry.count = 2'd3;
    unique case (pos_r)
      2'd0: begin
        grp_entry.triple = {acc_new[5:0], 18'd0};
        grp_entry.count  = 2'd1;
        emit             = char_fin;
      end
      2'd1: begin
        grp_entry.triple = {acc_new[11:0], 12'd0};
        grp_entry.count  = 2'd1;
        emit             = char_fin;
      end
      2'd2: begin
        grp_entry.triple = {acc_new, 6'd0};
        grp_entry.count  = is_pad ? 2'd1 : 2'd2;
        emit             = char_fin;
      end
      default: begin
        grp_entry.triple = {acc_r, sextet};
        grp_entry.count  = char_fin ? 2'(2'd3 - {1'b0, twp_r} - {1'b0, is_pad}) : 2'd3;
        emit             = 1'b1;
      end
    endcase
  end

  assign grp_push = char_valid && emit;

  always_comb begin
    acc_nxt = acc_r;
    pos_nxt = pos_r;
    twp_nxt = twp_r;
    if (char_valid) begin
      if (emit) begin
        acc_nxt = 18'd0;
        pos_nxt = 2'd0;
        twp_nxt = 1'b0;
      end else begin
        acc_nxt = acc_new;
        pos_nxt = pos_r + 2'd1;
        twp_nxt = (pos_r == 2'd2) ? is_pad : twp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= 18'd0;
      pos_r <= 2'd0;
      twp_r <= 1'b0;
    end else begin
      acc_r <= acc_nxt;
      pos_r <= pos_nxt;
      twp_r <= twp_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/b64d_queue.sv -----
// Short group queue that decouples the decoder front end from the byte
// serializer. Depends on b64d_pkg.
`default_nettype none

module b64d_queue
  import b64d_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         wr_en,
  input  wire group_entry_t wr_entry,
  output logic              q_full,
  input  wire logic         rd_en,
  output group_entry_t      rd_entry,
  output logic              q_empty
);

  group_entry_t              slots_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]         cnt_r, cnt_nxt;

  assign q_full   = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign q_empty  = (cnt_r == '0);
  assign rd_entry = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(wr_en);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(rd_en);
    cnt_nxt    = cnt_r + QCNT_W'(wr_en) - QCNT_W'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots_r[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/b64d_back.sv -----
// Back end of the base64url stream decoder: splits queued groups into
// bytes and holds each byte in the output register. Depends on b64d_pkg.
`default_nettype none

module b64d_back
  import b64d_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire group_entry_t head,
  input  wire logic         head_empty,
  output logic              head_pop,
  output logic [7:0]        byte_data,
  output logic              byte_fin,
  output logic              byte_valid,
  input  wire logic         byte_taken
);

  logic [1:0] idx_r, idx_nxt;
  logic [7:0] data_r, data_nxt;
  logic       fin_r, fin_nxt;
  logic       valid_r, valid_nxt;

  logic       load;
  logic       last;
  logic [7:0] cur_byte;

  assign load = !head_empty && (!valid_r || byte_taken);
  assign last = ((idx_r + 2'd1) == head.count);

  always_comb begin
    unique case (idx_r)
      2'd0:    cur_byte = head.triple[23:16];
      2'd1:    cur_byte = head.triple[15:8];
      default: cur_byte = head.triple[7:0];
    endcase
  end

  assign head_pop = load && last;

  always_comb begin
    idx_nxt   = idx_r;
    data_nxt  = data_r;
    fin_nxt   = fin_r;
    valid_nxt = valid_r;
    if (load) begin
      data_nxt  = cur_byte;
      fin_nxt   = head.fin && last;
      valid_nxt = 1'b1;
      idx_nxt   = last ? 2'd0 : idx_r + 2'd1;
    end else if (byte_taken) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    fin_r  <= fin_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign byte_data  = data_r;
  assign byte_fin   = fin_r;
  assign byte_valid = valid_r;

endmodule

`default_nettype wire

// ----- rtl/base64url_stream_decoder.sv -----
// Top level of the base64url stream decoder. Instantiates the front end,
// the group queue and the byte serializer; depends on b64d_pkg.
//
// The decoder takes one character per beat and returns decoded bytes, one
// per beat. Both the standard alphabet ('+', '/') and the URL-safe one
// ('-', '_') are accepted; '=' and any unknown character decode as a zero
// sextet without error. Every group of four characters that does not close
// the text yields three bytes. A character flagged final closes the text: a
// short group counts as padded with '=', the closing group yields three
// bytes less one for each '=' in its third and fourth places, its last byte
// carries out_is_final_byte, and the next character starts a new text. The
// block accepts one character per clock cycle while in_full is low, each
// classified and folded into the group as it is accepted; a completed group
// enters a four-entry queue. The serializer drains it at one byte per cycle
// while results are popped; a byte passes a queue slot and then the output
// register. in_full rises only when the queue is full because results are
// not being popped; there is no warm-up after reset.
`default_nettype none

module base64url_stream_decoder
  import b64d_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  output logic            in_full,
  input  wire logic [7:0] in_text_char,
  input  wire logic       in_is_final_char,
  output logic            out_empty,
  input  wire logic       out_pop,
  output logic [7:0]      out_data_byte,
  output logic            out_is_final_byte
);

  group_entry_t grp_entry;
  group_entry_t head;
  logic         grp_push;
  logic         q_full;
  logic         q_empty;
  logic         head_pop;
  logic         char_valid;
  logic         byte_valid;

  // A character is taken only when the queue has room for the group it
  // might complete, so no accepted character ever has to wait.
  assign in_full    = q_full;
  assign char_valid = in_push && !q_full;

  b64d_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .char_valid (char_valid),
    .char_code  (in_text_char),
    .char_fin   (in_is_final_char),
    .grp_entry  (grp_entry),
    .grp_push   (grp_push)
  );

  b64d_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (grp_push),
    .wr_entry (grp_entry),
    .q_full   (q_full),
    .rd_en    (head_pop),
    .rd_entry (head),
    .q_empty  (q_empty)
  );

  // The serializer's output register parts the result side from the queue,
  // so a waiting byte stops characters from being accepted only once the queue is full.
  b64d_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_empty (q_empty),
    .head_pop   (head_pop),
    .byte_data  (out_data_byte),
    .byte_fin   (out_is_final_byte),
    .byte_valid (byte_valid),
    .byte_taken (out_pop)
  );

  assign out_empty = !byte_valid;

endmodule

`default_nettype wire

// ----- rtl/b64d_checker.sv -----
// Port-level checker for the base64url stream decoder and the bind that
// attaches it to the top level. Depends on base64url_stream_decoder.
`default_nettype none

module b64d_checker (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  input  wire logic       in_full,
  input  wire logic [7:0] in_text_char,
  input  wire logic       in_is_final_char,
  input  wire logic       out_empty,
  input  wire logic       out_pop,
  input  wire logic [7:0] out_data_byte,
  input  wire logic       out_is_final_byte
);

  // Reset leaves no result pending and room for input.
  a_reset_empty : assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("result pending or input blocked right after reset");

  // Backpressure on input can only come from results that wait to be taken.
  a_full_has_result : assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> !out_empty)
    else $error("input blocked while no result is offered");

  // A stalled result beat holds its value.
  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_data_byte)
                                && $stable(out_is_final_byte))
    else $error("result beat changed while stalled");

  // An offered character beat carries known values.
  a_in_known : assert property (@(posedge clk) disable iff (!rst_n)
    in_push |-> !$isunknown({in_text_char, in_is_final_char}))
    else $error("character beat offered with unknown bits");

  // A final character always closes a group, so a byte is offered soon after.
  a_final_gives_byte : assert property (@(posedge clk) disable iff (!rst_n)
    in_push && !in_full && in_is_final_char |-> ##2 !out_empty)
    else $error("no byte offered after a final character");

endmodule

bind base64url_stream_decoder b64d_checker u_b64d_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_push           (in_push),
  .in_full           (in_full),
  .in_text_char      (in_text_char),
  .in_is_final_char  (in_is_final_char),
  .out_empty         (out_empty),
  .out_pop           (out_pop),
  .out_data_byte     (out_data_byte),
  .out_is_final_byte (out_is_final_byte)
);

`default_nettype wire
